/* rtl/core/fbm_pkg.sv */
// Shared types, constants and arithmetic helpers of the fBm Perlin noise block.
`timescale 1ns / 1ps
package fbm_pkg;

   localparam int MAX_OCTAVES_DEF = 8;
   localparam int PERM_SIZE       = 256;

   // Configuration register indexes
   typedef enum logic [2:0] {
      REG_OCTAVE_COUNT   = 3'd0,
      REG_BASE_FREQUENCY = 3'd1,
      REG_BASE_AMPLITUDE = 3'd2,
      REG_FREQUENCY_STEP = 3'd3,
      REG_AMPLITUDE_GAIN = 3'd4
   } csr_index_type;

   // Point sequencer states
   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_RUN  = 2'd1,
      ST_DONE = 2'd2
   } seq_state_type;

   localparam logic [7:0] PERM_ROM [PERM_SIZE] = '{
      8'd151, 8'd160, 8'd137, 8'd91,  8'd90,  8'd15,  8'd131, 8'd13,  8'd201, 8'd95,
      8'd96,  8'd53,  8'd194, 8'd233, 8'd7,   8'd225, 8'd140, 8'd36,  8'd103, 8'd30,
      8'd69,  8'd142, 8'd8,   8'd99,  8'd37,  8'd240, 8'd21,  8'd10,  8'd23,  8'd190,
      8'd6,   8'd148, 8'd247, 8'd120, 8'd234, 8'd75,  8'd0,   8'd26,  8'd197, 8'd62,
      8'd94,  8'd252, 8'd219, 8'd203, 8'd117, 8'd35,  8'd11,  8'd32,  8'd57,  8'd177,
      8'd33,  8'd88,  8'd237, 8'd149, 8'd56,  8'd87,  8'd174, 8'd20,  8'd125, 8'd136,
      8'd171, 8'd168, 8'd68,  8'd175, 8'd74,  8'd165, 8'd71,  8'd134, 8'd139, 8'd48,
      8'd27,  8'd166, 8'd77,  8'd146, 8'd158, 8'd231, 8'd83,  8'd111, 8'd229, 8'd122,
      8'd60,  8'd211, 8'd133, 8'd230, 8'd220, 8'd105, 8'd92,  8'd41,  8'd55,  8'd46,
      8'd245, 8'd40,  8'd244, 8'd102, 8'd143, 8'd54,  8'd65,  8'd25,  8'd63,  8'd161,
      8'd1,   8'd216, 8'd80,  8'd73,  8'd209, 8'd76,  8'd132, 8'd187, 8'd208, 8'd89,
      8'd18,  8'd169, 8'd200, 8'd196, 8'd135, 8'd130, 8'd116, 8'd188, 8'd159, 8'd86,
      8'd164, 8'd100, 8'd109, 8'd198, 8'd173, 8'd186, 8'd3,   8'd64,  8'd52,  8'd217,
      8'd226, 8'd250, 8'd124, 8'd123, 8'd5,   8'd202, 8'd38,  8'd147, 8'd118, 8'd126,
      8'd255, 8'd82,  8'd85,  8'd212, 8'd207, 8'd206, 8'd59,  8'd227, 8'd47,  8'd16,
      8'd58,  8'd17,  8'd182, 8'd189, 8'd28,  8'd42,  8'd223, 8'd183, 8'd170, 8'd213,
      8'd119, 8'd248, 8'd152, 8'd2,   8'd44,  8'd154, 8'd163, 8'd70,  8'd221, 8'd153,
      8'd101, 8'd155, 8'd167, 8'd43,  8'd172, 8'd9,   8'd129, 8'd22,  8'd39,  8'd253,
      8'd19,  8'd98,  8'd108, 8'd110, 8'd79,  8'd113, 8'd224, 8'd232, 8'd178, 8'd185,
      8'd112, 8'd104, 8'd218, 8'd246, 8'd97,  8'd228, 8'd251, 8'd34,  8'd242, 8'd193,
      8'd238, 8'd210, 8'd144, 8'd12,  8'd191, 8'd179, 8'd162, 8'd241, 8'd81,  8'd51,
      8'd145, 8'd235, 8'd249, 8'd14,  8'd239, 8'd107, 8'd49,  8'd192, 8'd214, 8'd31,
      8'd181, 8'd199, 8'd106, 8'd157, 8'd184, 8'd84,  8'd204, 8'd176, 8'd115, 8'd121,
      8'd50,  8'd45,  8'd127, 8'd4,   8'd150, 8'd254, 8'd138, 8'd236, 8'd205, 8'd93,
      8'd222, 8'd114, 8'd67,  8'd29,  8'd24,  8'd72,  8'd243, 8'd141, 8'd128, 8'd195,
      8'd78,  8'd66,  8'd215, 8'd61,  8'd156, 8'd180
   };

   // Gradient dot product for one corner, picked by the low hash nibble from the cube edge directions
   function automatic logic signed [18:0] grad_dot(input logic [3:0] h,
                                                   input logic signed [17:0] x,
                                                   input logic signed [17:0] y,
                                                   input logic signed [17:0] z);
      logic signed [18:0] u;
      logic signed [18:0] v;
      u = (h < 4'd8) ? 19'(x) : 19'(y);
      if (h < 4'd4) begin
         v = 19'(y);
      end else if (h == 4'd12 || h == 4'd14) begin
         v = 19'(x);
      end else begin
         v = 19'(z);
      end
      if (h[0]) u = -u;
      if (h[1]) v = -v;
      return u + v;
   endfunction

   // a + floor(f * (b - a) / 65536)
   function automatic logic signed [18:0] lerp_q16(input logic signed [18:0] a,
                                                   input logic signed [18:0] b,
                                                   input logic [16:0] f);
      logic signed [19:0] d;
      logic signed [37:0] p;
      d = 20'(b) - 20'(a);
      p = 38'($signed({1'b0, f})) * 38'(d);
      return a + 19'(p >>> 16);
   endfunction

endpackage

/* rtl/core/fbm_perlin_noise_3d_top.sv */
// Top level of the fBm improved Perlin noise block: sequencer and octave pipeline.
//
//  channel | direction | handshake          | payload
//  req     | in        | req_tvalid/tready  | tdata: coord_x, coord_y, coord_z
//  rsp     | out       | rsp_tvalid/tready  | tdata: noise_sum, amplitude_total
//  csr     | in        | csr_valid/ready    | csr_index, csr_data
//
// One octave enters the nine-stage octave pipeline per cycle while the sequencer runs,
// for n octaves, n the clamped octave count. The next point is accepted once the
// previous sum is in the output register. Reset is synchronous; it empties the pipeline
// and loads the register defaults. A stalled result holds in the output register;
// a finished sum waits with the sequencer in its done state until the register is free.
`timescale 1ns / 1ps
module fbm_perlin_noise_3d_top
   import fbm_pkg::*;
#(
   parameter int MAX_OCTAVES = MAX_OCTAVES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [95:0] req_tdata,   // coord_x[31:0], coord_y[63:32], coord_z[95:64]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // noise_sum[31:0], amplitude_total[63:32]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [23:0] csr_data
);

   localparam int CNT_W = $clog2(MAX_OCTAVES + 1);

   // Configuration registers
   logic [3:0]  octave_count_ff;
   logic [23:0] base_frequency_ff, base_amplitude_ff, frequency_step_ff, amplitude_gain_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         octave_count_ff   <= 4'd4;
         base_frequency_ff <= 24'd65536;
         base_amplitude_ff <= 24'd65536;
         frequency_step_ff <= 24'd131072;
         amplitude_gain_ff <= 24'd32768;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_OCTAVE_COUNT:   octave_count_ff   <= csr_data[3:0];
            REG_BASE_FREQUENCY: base_frequency_ff <= csr_data;
            REG_BASE_AMPLITUDE: base_amplitude_ff <= csr_data;
            REG_FREQUENCY_STEP: frequency_step_ff <= csr_data;
            REG_AMPLITUDE_GAIN: amplitude_gain_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Sequencer registers
   seq_state_type state_ff, state_in;
   logic signed [31:0] coord_ff [3];
   logic [CNT_W-1:0]   octs_ff, issued_ff, retired_ff;
   logic [23:0]        freq_ff, amp_ff;
   logic signed [35:0] sum_ff;
   logic [32:0]        amp_sum_ff;
   logic               issue, load_out, accept;
   logic [CNT_W-1:0]   octs_in;
   logic [47:0]        freq_prod, amp_prod;
   logic [23:0]        freq_in, amp_in;
   logic               rsp_tvalid_ff;
   logic [63:0]        rsp_tdata_ff;
   logic               v9_ff;
   logic signed [27:0] term9_ff;

   assign accept = req_tvalid && req_tready;
   assign octs_in = (int'(octave_count_ff) > MAX_OCTAVES) ? CNT_W'(MAX_OCTAVES)
                                                           : CNT_W'(octave_count_ff);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (accept) state_in = ST_RUN;
         ST_RUN:  if (retired_ff == octs_ff) state_in = ST_DONE;
         ST_DONE: if (!rsp_tvalid_ff || rsp_tready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs
   always_comb begin
      req_tready = 1'b0;
      issue      = 1'b0;
      load_out   = 1'b0;
      unique case (state_ff)
         ST_IDLE: req_tready = 1'b1;
         ST_RUN:  issue      = (issued_ff != octs_ff);
         ST_DONE: load_out   = !rsp_tvalid_ff || rsp_tready;
         default: ;
      endcase
   end

   // Next octave frequency and amplitude, saturated to 24 bits
   assign freq_prod = 48'(freq_ff) * 48'(frequency_step_ff);
   assign amp_prod  = 48'(amp_ff) * 48'(amplitude_gain_ff);
   assign freq_in   = (|freq_prod[47:40]) ? 24'hFFFFFF : freq_prod[39:16];
   assign amp_in    = (|amp_prod[47:40]) ? 24'hFFFFFF : amp_prod[39:16];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         issued_ff  <= '0;
         retired_ff <= '0;
         octs_ff    <= '0;
      end else begin
         state_ff <= state_in;
         if (accept) begin
            issued_ff  <= '0;
            retired_ff <= '0;
            octs_ff    <= octs_in;
         end else begin
            if (issue) issued_ff <= issued_ff + 1'b1;
            if (v9_ff) retired_ff <= retired_ff + 1'b1;
         end
      end
   end

   // Point, octave scale and accumulators
   always_ff @(posedge clock) begin
      if (accept) begin
         coord_ff[0] <= req_tdata[31:0];
         coord_ff[1] <= req_tdata[63:32];
         coord_ff[2] <= req_tdata[95:64];
         freq_ff     <= base_frequency_ff;
         amp_ff      <= base_amplitude_ff;
         sum_ff      <= '0;
         amp_sum_ff  <= '0;
      end else begin
         if (issue) begin
            freq_ff    <= freq_in;
            amp_ff     <= amp_in;
            amp_sum_ff <= amp_sum_ff + 33'(amp_ff);
         end
         if (v9_ff) sum_ff <= sum_ff + 36'(term9_ff);
      end
   end

   // ---------------- Octave pipeline ----------------
   logic               v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, v7_ff, v8_ff;
   logic [23:0]        a1_ff, a2_ff, a3_ff, a4_ff, a5_ff, a6_ff, a7_ff, a8_ff;
   logic [7:0]         c1_ff [3];
   logic [15:0]        t1_ff [3], t2_ff [3], t3_ff [3], t4_ff [3];
   logic [15:0]        sq2_ff [3], r3_ff [3];
   logic [19:0]        q2_ff [3], q3_ff [3];
   logic [7:0]         ha2_ff, hb2_ff, z2_ff;
   logic [7:0]         hh3_ff [4];
   logic [16:0]        f4_ff [3], f5_ff [3];
   logic [16:0]        fv6_ff, fw6_ff, fw7_ff;
   logic [7:0]         h4_ff [8];
   logic signed [18:0] g5_ff [8], l6_ff [4], l7_ff [2], n8_ff;
   logic [56:0]        scaled [3];
   logic [31:0]        tt [3];
   logic [39:0]        qq [3];
   logic [31:0]        rr [3];
   logic [35:0]        ff [3];
   logic signed [17:0] p0 [3], p1 [3];
   logic [7:0]         ca, cb;
   logic signed [43:0] term_prod;

   // Stage 1: scale the point and split into cell and fraction
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         scaled[k] = 57'($signed({{25{coord_ff[k][31]}}, coord_ff[k]})
                   * $signed({33'd0, freq_ff}));
      end
   end

   // Stage 2: fade squares and polynomial, first hash level
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         tt[k] = 32'(t1_ff[k]) * 32'(t1_ff[k]);
         qq[k] = 40'hA_0000_0000 + 40'(tt[k]) * 40'd6 - ((40'(t1_ff[k]) * 40'd15) << 16);
      end
   end

   // Stage 3: fade cube, second hash level
   always_comb begin
      for (int k = 0; k < 3; k++) rr[k] = 32'(sq2_ff[k]) * 32'(t2_ff[k]);
   end

   // Stage 4: fade result, corner hashes
   always_comb begin
      for (int k = 0; k < 3; k++) ff[k] = 36'(r3_ff[k]) * 36'(q3_ff[k]);
   end

   // Stage 5: corner offsets
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         p0[k] = $signed({2'b00, t4_ff[k]});
         p1[k] = $signed({2'b00, t4_ff[k]}) - 18'sd65536;
      end
   end

   assign ca = PERM_ROM[c1_ff[0]] + c1_ff[1];
   assign cb = PERM_ROM[c1_ff[0] + 8'd1] + c1_ff[1];
   assign term_prod = 44'(n8_ff) * 44'($signed({1'b0, a8_ff}));

   always_ff @(posedge clock) begin
      if (reset) begin
         {v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, v7_ff, v8_ff, v9_ff} <= '0;
      end else begin
         {v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, v7_ff, v8_ff, v9_ff} <=
            {issue, v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, v7_ff, v8_ff};
      end
   end

   // Advance the payload of every stage each cycle
   always_ff @(posedge clock) begin
      for (int k = 0; k < 3; k++) begin
         c1_ff[k]  <= scaled[k][39:32];
         t1_ff[k]  <= scaled[k][31:16];
         t2_ff[k]  <= t1_ff[k];
         sq2_ff[k] <= tt[k][31:16];
         q2_ff[k]  <= qq[k][35:16];
         t3_ff[k]  <= t2_ff[k];
         r3_ff[k]  <= rr[k][31:16];
         q3_ff[k]  <= q2_ff[k];
         t4_ff[k]  <= t3_ff[k];
         f4_ff[k]  <= ff[k][32:16];
         f5_ff[k]  <= f4_ff[k];
      end
      ha2_ff    <= ca;
      hb2_ff    <= cb;
      z2_ff     <= c1_ff[2];
      hh3_ff[0] <= PERM_ROM[ha2_ff] + z2_ff;
      hh3_ff[1] <= PERM_ROM[ha2_ff + 8'd1] + z2_ff;
      hh3_ff[2] <= PERM_ROM[hb2_ff] + z2_ff;
      hh3_ff[3] <= PERM_ROM[hb2_ff + 8'd1] + z2_ff;
      // corner k = z*4 + y*2 + x
      h4_ff[0] <= PERM_ROM[hh3_ff[0]];
      h4_ff[1] <= PERM_ROM[hh3_ff[2]];
      h4_ff[2] <= PERM_ROM[hh3_ff[1]];
      h4_ff[3] <= PERM_ROM[hh3_ff[3]];
      h4_ff[4] <= PERM_ROM[hh3_ff[0] + 8'd1];
      h4_ff[5] <= PERM_ROM[hh3_ff[2] + 8'd1];
      h4_ff[6] <= PERM_ROM[hh3_ff[1] + 8'd1];
      h4_ff[7] <= PERM_ROM[hh3_ff[3] + 8'd1];
      for (int c = 0; c < 8; c++) begin
         g5_ff[c] <= grad_dot(h4_ff[c][3:0], c[0] ? p1[0] : p0[0],
                              c[1] ? p1[1] : p0[1], c[2] ? p1[2] : p0[2]);
      end
      for (int j = 0; j < 4; j++) l6_ff[j] <= lerp_q16(g5_ff[2*j], g5_ff[2*j+1], f5_ff[0]);
      fv6_ff   <= f5_ff[1];
      fw6_ff   <= f5_ff[2];
      l7_ff[0] <= lerp_q16(l6_ff[0], l6_ff[1], fv6_ff);
      l7_ff[1] <= lerp_q16(l6_ff[2], l6_ff[3], fv6_ff);
      fw7_ff   <= fw6_ff;
      n8_ff    <= lerp_q16(l7_ff[0], l7_ff[1], fw7_ff);
      term9_ff <= 28'(term_prod >>> 16);
      a1_ff <= amp_ff;
      a2_ff <= a1_ff;
      a3_ff <= a2_ff;
      a4_ff <= a3_ff;
      a5_ff <= a4_ff;
      a6_ff <= a5_ff;
      a7_ff <= a6_ff;
      a8_ff <= a7_ff;
   end

   // Output register: saturate and hold until the transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         if (sum_ff > 36'sd2147483647) begin
            rsp_tdata_ff[31:0] <= 32'h7FFFFFFF;
         end else if (sum_ff < -36'sd2147483648) begin
            rsp_tdata_ff[31:0] <= 32'h80000000;
         end else begin
            rsp_tdata_ff[31:0] <= sum_ff[31:0];
         end
         rsp_tdata_ff[63:32] <= amp_sum_ff[32] ? 32'hFFFFFFFF : amp_sum_ff[31:0];
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule

/* rtl/core/fbm_chk.sv */
// Port checker of the fBm Perlin noise block, bound to the top level.
`timescale 1ns / 1ps
module fbm_chk (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata
);

   // Hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // Take one point at a time
   a_one_point: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second point accepted while busy");

   // A new result appears only while no point is being taken
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> !$past(req_tready))
      else $error("result loaded while idle");

   // Come out of reset with no result pending
   a_reset_empty: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_tvalid)
      else $error("result pending after reset");

endmodule

bind fbm_perlin_noise_3d_top fbm_chk u_fbm_chk (.*);

/* test/fbm_perlin_noise_3d_checker.sv */
// Checker for the fBm Perlin noise block: predicts each point's sums and compares results.
`timescale 1ns / 1ps
module fbm_perlin_noise_3d_checker
   import fbm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [95:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [63:0] rsp_tdata,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [23:0] csr_data,
   output int          fail_count,
   output int          pending_count
);

   localparam longint ONE = 65536;
   localparam longint MASK24 = 64'hFFFFFF;

   logic [3:0]  octaves;
   logic [23:0] freq0;
   logic [23:0] amp0;
   logic [23:0] freq_mul;
   logic [23:0] amp_mul;
   logic [63:0] sums_q[$];

   function automatic longint fdiv16(longint x);
      return x >>> 16;
   endfunction

   function automatic longint fade(longint t);
      longint q;
      longint r;
      q = 10 * ONE * ONE + 6 * t * t - 15 * t * ONE;
      r = (t * t) >> 16;
      r = (r * t) >> 16;
      return (r * (q >> 16)) >> 16;
   endfunction

   function automatic longint corner(int h, longint x, longint y, longint z);
      longint u;
      longint v;
      h = h & 15;
      u = (h < 8) ? x : y;
      v = (h < 4) ? y : ((h == 12 || h == 14) ? x : z);
      return ((h & 1) ? -u : u) + ((h & 2) ? -v : v);
   endfunction

   function automatic longint blend(longint a, longint b, longint f);
      return a + fdiv16(f * (b - a));
   endfunction

   function automatic int pm(int i);
      return PERM_ROM[i & 255];
   endfunction

   function automatic longint noise_at(longint cx, longint cy, longint cz, longint fr);
      logic [63:0] p;
      int lat[3];
      longint fr0[3];
      longint c[3];
      longint fu, fv, fw, x1, y1, z1;
      int a, aa, ab, b, ba, bb;
      longint g0, g1, g2, g3, g4, g5, g6, g7;
      c[0] = cx; c[1] = cy; c[2] = cz;
      for (int k = 0; k < 3; k++) begin
         p = c[k] * fr;
         lat[k] = p[39:32];
         fr0[k] = p[31:16];
      end
      x1 = fr0[0] - ONE; y1 = fr0[1] - ONE; z1 = fr0[2] - ONE;
      fu = fade(fr0[0]); fv = fade(fr0[1]); fw = fade(fr0[2]);
      a = pm(lat[0]) + lat[1];
      aa = pm(a) + lat[2];
      ab = pm(a + 1) + lat[2];
      b = pm(lat[0] + 1) + lat[1];
      ba = pm(b) + lat[2];
      bb = pm(b + 1) + lat[2];
      g0 = corner(pm(aa), fr0[0], fr0[1], fr0[2]);
      g1 = corner(pm(ba), x1, fr0[1], fr0[2]);
      g2 = corner(pm(ab), fr0[0], y1, fr0[2]);
      g3 = corner(pm(bb), x1, y1, fr0[2]);
      g4 = corner(pm(aa + 1), fr0[0], fr0[1], z1);
      g5 = corner(pm(ba + 1), x1, fr0[1], z1);
      g6 = corner(pm(ab + 1), fr0[0], y1, z1);
      g7 = corner(pm(bb + 1), x1, y1, z1);
      return blend(blend(blend(g0, g1, fu), blend(g2, g3, fu), fv),
                   blend(blend(g4, g5, fu), blend(g6, g7, fu), fv), fw);
   endfunction

   function automatic longint rescale(longint a, longint m);
      longint r;
      r = (a * m) >> 16;
      return (r > MASK24) ? MASK24 : r;
   endfunction

   function automatic logic [63:0] fbm_sums(logic [95:0] pt);
      longint cx, cy, cz, fr, am, total, amp_total;
      int n;
      cx = longint'($signed(pt[31:0]));
      cy = longint'($signed(pt[63:32]));
      cz = longint'($signed(pt[95:64]));
      n = (octaves > 8) ? 8 : octaves;
      fr = freq0; am = amp0; total = 0; amp_total = 0;
      for (int i = 0; i < n; i++) begin
         total += fdiv16(noise_at(cx, cy, cz, fr) * am);
         amp_total += am;
         fr = rescale(fr, freq_mul);
         am = rescale(am, amp_mul);
      end
      if (total > 64'sh7FFFFFFF) total = 64'sh7FFFFFFF;
      if (total < -64'sh80000000) total = -64'sh80000000;
      if (amp_total > 64'hFFFFFFFF) amp_total = 64'hFFFFFFFF;
      return {amp_total[31:0], total[31:0]};
   endfunction

   assign pending_count = sums_q.size();

   // Track registers, queue predictions, compare results
   always @(posedge clock) begin
      logic [63:0] want;
      int          errs;
      errs = 0;
      if (reset) begin
         octaves <= 4'd4; freq0 <= 24'd65536; amp0 <= 24'd65536;
         freq_mul <= 24'd131072; amp_mul <= 24'd32768;
         sums_q.delete();
         fail_count <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_OCTAVE_COUNT:   octaves <= csr_data[3:0];
               REG_BASE_FREQUENCY: freq0 <= csr_data;
               REG_BASE_AMPLITUDE: amp0 <= csr_data;
               REG_FREQUENCY_STEP: freq_mul <= csr_data;
               REG_AMPLITUDE_GAIN: amp_mul <= csr_data;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) sums_q.push_back(fbm_sums(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            if (sums_q.size() == 0) begin
               $display("%0t: unexpected result %h", $time, rsp_tdata);
               errs++;
            end else begin
               want = sums_q.pop_front();
               if (want[31:0] !== rsp_tdata[31:0]) begin
                  $display("%0t: noise_sum expected %h actual %h", $time, want[31:0],
                           rsp_tdata[31:0]);
                  errs++;
               end
               if (want[63:32] !== rsp_tdata[63:32]) begin
                  $display("%0t: amplitude_total expected %h actual %h", $time,
                           want[63:32], rsp_tdata[63:32]);
                  errs++;
               end
            end
         end
         fail_count <= fail_count + errs;
      end
   end

endmodule

/* test/fbm_perlin_noise_3d_top_test.sv */
// Testbench top for the fBm Perlin noise block: stimulus, register phases and verdict.
`timescale 1ns / 1ps
module fbm_perlin_noise_3d_top_test;
   import fbm_pkg::*;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [95:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [63:0] rsp_tdata;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [23:0] csr_data = '0;
   int          fail_count;
   int          pending_count;
   int          send_idle_pct;
   int          recv_idle_pct;

   fbm_perlin_noise_3d_top i_dut (.*);

   fbm_perlin_noise_3d_checker i_checker (.*);

   always #1 clock = ~clock;

   // Receiver stall
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Hold csr_valid high after the transfer; the caller drops it
   task automatic write_reg(csr_index_type idx, logic [23:0] value);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   // Hold req_tvalid high after the transfer; idling or drain drops it
   task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {z, y, x};
      do @(posedge clock); while (!req_tready);
   endtask

   function automatic logic [31:0] pick_coord();
      case ($urandom_range(5))
         0: return 32'h8000_0000 + $urandom_range(3);
         1: return 32'h7FFF_FFFF - $urandom_range(3);
         2: return $urandom_range(65535) - 32768;
         3: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
         default: return $urandom;
      endcase
   endfunction

   task automatic drain();
      req_tvalid <= 0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   // Set all registers for one phase
   task automatic set_regs(logic [3:0] n, logic [23:0] f, logic [23:0] a,
                           logic [23:0] fs, logic [23:0] ag);
      drain();
      write_reg(REG_OCTAVE_COUNT, {20'd0, n});
      write_reg(REG_BASE_FREQUENCY, f);
      write_reg(REG_BASE_AMPLITUDE, a);
      write_reg(REG_FREQUENCY_STEP, fs);
      write_reg(REG_AMPLITUDE_GAIN, ag);
      csr_valid <= 0;
   endtask

   task automatic random_points(int count);
      for (int i = 0; i < count; i++) send_point(pick_coord(), pick_coord(), pick_coord());
   endtask

   initial begin
      send_idle_pct = 35;
      recv_idle_pct = 76;
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // Directed: coordinate extremes at reset settings
      send_point(0, 0, 0);
      send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_point(32'hFFFF_FFFF, 32'h0001_0000, 32'h0000_8000);
      send_point(32'h0000_FFFF, 32'hFFFF_0001, 32'h1234_5678);
      // Zero octaves, count above the maximum, saturating frequency and amplitude
      set_regs(4'd0, 24'd65536, 24'd65536, 24'd131072, 24'd32768);
      send_point(32'h0001_8000, 32'h0002_4000, 32'h0003_C000);
      set_regs(4'd15, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
      send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_8000);
      send_point(32'h0000_8001, 32'h0000_7FFF, 32'hFFFF_8000);
      set_regs(4'd9, 24'd0, 24'd0, 24'd0, 24'd0);
      send_point(32'h1111_1111, 32'h2222_2222, 32'h3333_3333);
      set_regs(4'd1, 24'h010000, 24'hFFFFFF, 24'h010000, 24'h010000);
      for (int i = 0; i < 8; i++) send_point(pick_coord(), pick_coord(), pick_coord());
      set_regs(4'd8, 24'h008000, 24'h800000, 24'h020000, 24'hFFFFFF);
      send_point(32'h7FFF_0000, 32'h0000_FFFF, 32'h8001_0000);
      // Random phases across settings and idling patterns
      for (int ph = 0; ph < 6; ph++) begin
         if (ph == 2) begin send_idle_pct = 76; recv_idle_pct = 35; end
         if (ph == 4) begin send_idle_pct = 0; recv_idle_pct = 0; end
         set_regs(4'($urandom_range(9)),
                  24'($urandom_range(24'hFFFFFF) >> $urandom_range(23)),
                  24'($urandom), 24'($urandom_range(24'h040000)),
                  24'($urandom_range(24'h020000)));
         random_points(245);
      end
      drain();
      if (fail_count == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end

   initial begin
      #2000000;
      $display("tb: failure");
      $finish;
   end

endmodule
